/* sv/hrvz_pkg.sv */
`timescale 1ns / 1ps

package hrvz_pkg;

    // Stream payload widths in bits. The data widths are whole numbers of bytes.
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 160;
    localparam int OUT_USER_W = 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int NUM_THRESH = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd5;
    localparam logic [6:0] WLEN_RST = 7'd32;
    localparam logic [7:0] ZONE_UPPER_RST [NUM_THRESH] = '{8'd70, 8'd108, 8'd143, 8'd161, 8'd178};

    // Field and accumulator widths.
    localparam int RR_W     = 16;
    localparam int BPM_W    = 8;
    localparam int QZ_W     = 3;
    localparam int RMS_W    = 20;
    localparam int CNT_W    = 32;
    localparam int SQS_W    = 38;
    localparam logic [SQS_W-1:0] SQS_SAT = {SQS_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

    // Shared divider: up to a 46-bit dividend over a 32-bit divisor.
    localparam int DIV_NW = SQS_W + 8;
    localparam int DIV_DW = 32;
    localparam int DIV_SW = 6;
    localparam logic [DIV_SW-1:0] DIV_STEPS_WIN = 6'd46;
    localparam logic [DIV_SW-1:0] DIV_STEPS_AVG = 6'd32;

    // Square root of the 46-bit quotient gives a 23-bit root.
    localparam int SQ_NW = DIV_NW;
    localparam int SQ_RW = SQ_NW / 2;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_WSTART,
        S_WDIV,
        S_SQRT,
        S_BIN,
        S_QSTART,
        S_QDIV,
        S_QACC,
        S_DONE
    } t_state;

endpackage

/* sv/hrv_rmssd_zone_binner_top.sv */
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                     | Payload
// ---------+-----------+-------------------------------+------------------------------------
// s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata: command fields, tuser: opcode
// m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata: statistics, tuser: window_done
// cfg      | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// Every command transaction yields exactly one result transaction.
// A sample that closes a window also runs its mean square through the shared divider
// and then the square-root unit before its result is loaded. A query runs, for each
// non-empty zone, one division for its average through the same divider; an empty
// zone skips the divider.
// Reset is synchronous, active low, and clears all statistics and restores the
// threshold and window-length registers. The block takes no command while one is
// in progress; a finished result waits in the output register while the next
// command is already taken, and it stalls the sequencer only when a second result
// is ready before the first has been taken. Configuration writes are always accepted.
module hrv_rmssd_zone_binner_top
    import hrvz_pkg::*;
#(
    parameter int WINDOW_MAX = 64,
    parameter int ZONE_COUNT = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Command stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: sample_time[31:0], rr_ms[47:32], heart_rate[55:48], query_zone[58:56],
    //        zero fill [63:59].
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[1:0].
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: window_rmssd[19:0], current_zone[22:20], zone_average[42:23],
    //        zone_windows[74:43], total_windows[106:75], max_average[126:107],
    //        max_windows[158:127], zero fill [159].
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: window_done[0].
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Fill counter holds up to WINDOW_MAX; CW is wide enough for it and the register.
    localparam int FCW = $clog2(WINDOW_MAX + 1);
    localparam int CW  = (FCW > 7) ? FCW : 7;
    localparam int ZIW = $clog2(ZONE_COUNT);

    // Input field views.
    t_opcode            w_op;
    logic [31:0]        w_time;
    logic [RR_W-1:0]    w_rr;
    logic [BPM_W-1:0]   w_bpm;
    logic [QZ_W-1:0]    w_qz;

    assign w_op   = t_opcode'(s_axis_tuser);
    assign w_time = s_axis_tdata[31:0];
    assign w_rr   = s_axis_tdata[47:32];
    assign w_bpm  = s_axis_tdata[55:48];
    assign w_qz   = s_axis_tdata[58:56];

    // Configuration registers.
    logic [7:0]       r_zone_upper [NUM_THRESH];
    logic [6:0]       r_window_length;

    // Block state.
    t_state           r_state, n_state;
    logic             r_armed;
    logic [RR_W-1:0]  r_prev_rr;
    logic [FCW-1:0]   r_fill;
    logic [SQS_W-1:0] r_square_sum;
    logic [CNT_W-1:0] r_rmssd_sum [ZONE_COUNT];
    logic [CNT_W-1:0] r_window_count [ZONE_COUNT];
    logic [2:0]       r_last_zone;
    logic [ZIW-1:0]   r_zidx;

    // Per-command working registers.
    logic [BPM_W-1:0] r_bpm;
    logic [QZ_W-1:0]  r_qz;
    logic [RR_W-1:0]  r_diff;
    logic [31:0]      r_prod;
    logic [CNT_W-1:0] r_avg;
    logic             r_res_done;
    logic [RMS_W-1:0] r_res_rms;
    logic [RMS_W-1:0] r_res_zavg;
    logic [CNT_W-1:0] r_res_zwin;
    logic [CNT_W-1:0] r_res_total;
    logic [CNT_W-1:0] r_res_maxa;
    logic [CNT_W-1:0] r_res_maxw;

    // Output register.
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    // Sequencer strobes.
    logic              w_accept;
    logic              w_div_start;
    logic [DIV_NW-1:0] w_div_dividend;
    logic [DIV_DW-1:0] w_div_divisor;
    logic [DIV_SW-1:0] w_div_steps;
    logic              w_sq_start;
    logic              w_out_load;

    // Shared unit results.
    logic              w_div_done;
    logic [DIV_NW-1:0] w_quot;
    logic              w_sq_done;
    logic [SQ_RW-1:0]  w_root;

    // Datapath helpers.
    logic [CW-1:0]    w_len;
    logic             w_win_full;
    logic [SQS_W:0]   w_acc;
    logic [8:0]       w_thr [ZONE_COUNT];
    logic             w_zone_hit;
    logic [ZIW-1:0]   w_zone;
    logic [CNT_W:0]   w_zsum;
    logic [CNT_W:0]   w_total;
    logic             w_zcount_zero;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = s_axis_tvalid && s_axis_tready;

    // The effective window length is the register clamped to [2, WINDOW_MAX].
    always_comb begin
        w_len = CW'(r_window_length);
        if (w_len < CW'(2)) begin
            w_len = CW'(2);
        end else if (w_len > CW'(WINDOW_MAX)) begin
            w_len = CW'(WINDOW_MAX);
        end
    end

    assign w_win_full    = (CW'(r_fill) >= w_len);
    assign w_acc         = {1'b0, r_square_sum} + (SQS_W + 1)'(r_prod);
    assign w_zcount_zero = (r_window_count[r_zidx] == '0);

    // Zone search: zones beyond the five thresholds have an upper bound of 256.
    // The lowest zone whose bounds hold wins.
    always_comb begin
        logic lo_ok;
        logic hi_ok;
        w_zone_hit = 1'b0;
        w_zone     = '0;
        for (int k = 0; k < ZONE_COUNT; k++) begin
            w_thr[k] = (k < NUM_THRESH) ? {1'b0, r_zone_upper[(k < NUM_THRESH) ? k : 0]}
                                        : 9'd256;
        end
        for (int i = ZONE_COUNT - 1; i >= 0; i--) begin
            lo_ok = (i == 0) || ({1'b0, r_bpm} >= w_thr[(i > 0) ? i - 1 : 0]);
            hi_ok = (i == ZONE_COUNT - 1) || ({1'b0, r_bpm} < w_thr[i]);
            if (lo_ok && hi_ok) begin
                w_zone_hit = 1'b1;
                w_zone     = ZIW'(i);
            end
        end
    end

    assign w_zsum  = {1'b0, r_rmssd_sum[w_zone]} + (CNT_W + 1)'(w_root);
    assign w_total = {1'b0, r_res_total} + {1'b0, r_window_count[r_zidx]};

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (w_op) inside
                        OP_SAMPLE: begin
                            n_state = (w_time != '0 && r_armed) ? S_MUL : S_DONE;
                        end
                        OP_QUERY: begin
                            n_state = S_QSTART;
                        end
                        OP_CLEAR, OP_NOP: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL:    n_state = S_ACC;
            S_ACC:    n_state = w_win_full ? S_WSTART : S_DONE;
            S_WSTART: n_state = S_WDIV;
            S_WDIV:   n_state = w_div_done ? S_SQRT : S_WDIV;
            S_SQRT:   n_state = w_sq_done ? S_BIN : S_SQRT;
            S_BIN:    n_state = S_DONE;
            S_QSTART: n_state = w_zcount_zero ? S_QACC : S_QDIV;
            S_QDIV:   n_state = w_div_done ? S_QACC : S_QDIV;
            S_QACC:   n_state = (r_zidx == ZIW'(ZONE_COUNT - 1)) ? S_DONE : S_QSTART;
            S_DONE:   n_state = (!r_out_valid || m_axis_tready) ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_axis_tready  = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = {r_square_sum, 8'd0};
        w_div_divisor  = DIV_DW'(r_fill - FCW'(1));
        w_div_steps    = DIV_STEPS_WIN;
        w_sq_start     = 1'b0;
        w_out_load     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_WSTART: begin
                w_div_start = 1'b1;
            end
            S_WDIV: begin
                w_sq_start = w_div_done;
            end
            S_QSTART: begin
                w_div_start    = !w_zcount_zero;
                w_div_dividend = {r_rmssd_sum[r_zidx], (DIV_NW - CNT_W)'(0)};
                w_div_divisor  = r_window_count[r_zidx];
                w_div_steps    = DIV_STEPS_AVG;
            end
            S_DONE: begin
                w_out_load = !r_out_valid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_THRESH; i++) begin
                r_zone_upper[i] <= ZONE_UPPER_RST[i];
            end
            r_window_length <= WLEN_RST;
        end else if (i_cfg_valid) begin
            for (int i = 0; i < NUM_THRESH; i++) begin
                if (i_cfg_index == CFG_IDX_W'(i)) begin
                    r_zone_upper[i] <= i_cfg_data;
                end
            end
            if (i_cfg_index == CFG_WINDOW_LENGTH) begin
                r_window_length <= i_cfg_data[6:0];
            end
        end
    end

    // Control state and statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_armed      <= 1'b0;
            r_prev_rr    <= '0;
            r_fill       <= '0;
            r_square_sum <= '0;
            r_last_zone  <= '0;
            r_zidx       <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < ZONE_COUNT; i++) begin
                r_rmssd_sum[i]    <= '0;
                r_window_count[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (w_accept) begin
                r_zidx <= '0;
                unique case (w_op) inside
                    OP_SAMPLE: begin
                        if (w_time != '0) begin
                            if (!r_armed) begin
                                r_armed <= 1'b1;
                            end else begin
                                r_prev_rr <= w_rr;
                                r_fill    <= r_fill + FCW'(1);
                            end
                        end
                    end
                    OP_CLEAR: begin
                        r_armed      <= 1'b0;
                        r_prev_rr    <= '0;
                        r_fill       <= '0;
                        r_square_sum <= '0;
                        r_last_zone  <= '0;
                        for (int i = 0; i < ZONE_COUNT; i++) begin
                            r_rmssd_sum[i]    <= '0;
                            r_window_count[i] <= '0;
                        end
                    end
                    OP_QUERY, OP_NOP: begin
                        r_armed <= r_armed;
                    end
                endcase
            end

            if (r_state == S_ACC) begin
                r_square_sum <= w_acc[SQS_W] ? SQS_SAT : w_acc[SQS_W-1:0];
            end

            // A completed window restarts the window and is binned if a zone matches.
            if (r_state == S_BIN) begin
                r_fill       <= '0;
                r_square_sum <= '0;
                r_prev_rr    <= '0;
                if (w_zone_hit) begin
                    r_rmssd_sum[w_zone] <= w_zsum[CNT_W] ? CNT_SAT : w_zsum[CNT_W-1:0];
                    if (r_window_count[w_zone] != CNT_SAT) begin
                        r_window_count[w_zone] <= r_window_count[w_zone] + CNT_W'(1);
                    end
                    r_last_zone <= 3'(w_zone);
                end
            end

            if (r_state == S_QACC) begin
                r_zidx <= r_zidx + ZIW'(1);
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-command payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bpm       <= w_bpm;
            r_qz        <= w_qz;
            r_diff      <= (r_fill == '0) ? '0 :
                           (w_rr >= r_prev_rr) ? (w_rr - r_prev_rr) : (r_prev_rr - w_rr);
            r_res_done  <= 1'b0;
            r_res_rms   <= '0;
            r_res_zavg  <= '0;
            r_res_zwin  <= '0;
            r_res_total <= '0;
            r_res_maxa  <= '0;
            r_res_maxw  <= '0;
        end

        if (r_state == S_MUL) begin
            r_prod <= r_diff * r_diff;
        end

        if (r_state == S_BIN) begin
            r_res_done <= 1'b1;
            r_res_rms  <= w_root[RMS_W-1:0];
        end

        // An empty zone averages to zero; otherwise the divider supplies it.
        if (r_state == S_QSTART) begin
            r_avg <= '0;
        end else if (r_state == S_QDIV && w_div_done) begin
            r_avg <= w_quot[CNT_W-1:0];
        end

        if (r_state == S_QACC) begin
            r_res_total <= w_total[CNT_W] ? CNT_SAT : w_total[CNT_W-1:0];
            if (r_avg > r_res_maxa) begin
                r_res_maxa <= r_avg;
            end
            if (r_window_count[r_zidx] > r_res_maxw) begin
                r_res_maxw <= r_window_count[r_zidx];
            end
            if (QZ_W'(r_zidx) == r_qz) begin
                r_res_zavg <= r_avg[RMS_W-1:0];
                r_res_zwin <= r_window_count[r_zidx];
            end
        end

        if (w_out_load) begin
            r_out_user <= r_res_done;
            r_out_data <= {1'b0, r_res_maxw, r_res_maxa[RMS_W-1:0], r_res_total,
                           r_res_zwin, r_res_zavg, r_last_zone, r_res_rms};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Shared divider: mean square of a window, and per-zone averages for queries.
    hrvz_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .i_steps    (w_div_steps),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    hrvz_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_value (w_quot),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

endmodule

/* sv/hrvz_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The dividend is left-aligned,
// so a run of fewer steps divides only its upper bits.
module hrvz_div
    import hrvz_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    input  logic [DIV_SW-1:0] i_steps,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_SW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_work;
    logic [DIV_DW-1:0] r_dvs;
    logic [DIV_DW:0]   w_trial;
    logic [DIV_DW:0]   w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_work[DIV_NW-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_SW'(1);
                if (r_cnt == DIV_SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_work <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DIV_DW-1:0] : w_trial[DIV_DW-1:0];
            r_work <= {r_work[DIV_NW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_work;

endmodule

/* sv/hrvz_isqrt.sv */
`timescale 1ns / 1ps

// Bit-pair integer square root, one result bit per cycle.
module hrvz_isqrt
    import hrvz_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_NW-1:0] i_value,
    output logic             o_done,
    output logic [SQ_RW-1:0] o_root
);

    logic             r_busy;
    logic             r_done;
    logic [SQ_NW-1:0] r_v;
    logic [SQ_NW-1:0] r_r;
    logic [SQ_NW-1:0] r_bit;
    logic [SQ_NW:0]   w_sum;
    logic             w_take;

    assign w_sum  = {1'b0, r_r} + {1'b0, r_bit};
    assign w_take = ({1'b0, r_v} >= w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= SQ_NW'(1) << (SQ_NW - 2);
        end else if (r_busy) begin
            if (w_take) begin
                r_v <= r_v - w_sum[SQ_NW-1:0];
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[SQ_RW-1:0];

endmodule

/* sv/hrvz_checker.sv */
`timescale 1ns / 1ps

module hrvz_checker
    import hrvz_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // One command at a time: the block is busy right after it takes one.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command taken while busy");

    // A result without a completed window carries no RMSSD.
    a_rms_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[19:0] == 20'd0)
        else $error("RMSSD reported without a window");

    // Zone count never exceeds the maximum count, which never exceeds the total.
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[74:43] <= m_axis_tdata[158:127])
                       && (m_axis_tdata[158:127] <= m_axis_tdata[106:75]))
        else $error("window counts out of order");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind hrv_rmssd_zone_binner_top hrvz_checker u_hrvz_checker (.*);
